### rtl/blss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blss_pkg
// Shared sizes, request and status codes, cell commands and the control
// struct that the sequencer drives along the row of list cells.
// ----------------------------------------------------------------------------
package blss_pkg;

    localparam int DEPTH    = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // request codes
    localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SORT    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SEARCH  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READOUT = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // cell commands
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_HOLD   = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_ROTATE = 3'd2;
    localparam logic [OP_W-1:0] OP_DROP   = 3'd3;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic                     phase;
        logic [CNT_W-1:0]         fill;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

### rtl/blss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blss_cell
// One list slot: holds an entry, takes the tail write, shifts from its right
// neighbour for walks and removal, and does a compare-exchange for sorting.
// ----------------------------------------------------------------------------
module blss_cell import blss_pkg::*; (
    input  logic                     aclk,
    input  cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]         index,
    input  logic signed [DATA_W-1:0] left_entry,
    input  logic signed [DATA_W-1:0] right_entry,
    input  logic signed [DATA_W-1:0] head_entry,
    input  logic                     left_swap,
    output logic signed [DATA_W-1:0] entry,
    output logic                     swap_out
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic [CNT_W-1:0]         index_inc;
    logic                     left_role;

    assign index_inc = CNT_W'(index + 1'b1);
    assign left_role = (index[0] == ctrl.phase);

    always_comb begin
        swap_out   = 1'b0;
        entry_next = entry_reg;
        case (ctrl.op)
            OP_APPEND: begin
                if (index == ctrl.fill) begin
                    entry_next = ctrl.value;
                end
            end
            OP_ROTATE: begin
                if (index_inc == ctrl.fill) begin
                    entry_next = head_entry;
                end else if (index_inc < ctrl.fill) begin
                    entry_next = right_entry;
                end
            end
            OP_DROP: begin
                if (index_inc < ctrl.fill) begin
                    entry_next = right_entry;
                end
            end
            OP_SORT: begin
                if (left_role) begin
                    if (index_inc < ctrl.fill && entry_reg > right_entry) begin
                        swap_out   = 1'b1;
                        entry_next = right_entry;
                    end
                end else if (left_swap) begin
                    entry_next = left_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### rtl/blss_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blss_seq
// Request sequencer: decodes a request, steps the cell row one move per cycle
// unless the output stalls, keeps the fill count, drives the result register.
// ----------------------------------------------------------------------------
module blss_seq import blss_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [FUNC_W-1:0]          s_func,
    input  logic signed [DATA_W-1:0]   s_value,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [DATA_W-1:0]   m_entry,
    output logic [COUNT_W-1:0]         m_count,
    output logic                       m_last,
    input  logic signed [DATA_W-1:0]   head_entry,
    output cell_ctrl_t                 ctrl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_SORT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [FUNC_W-1:0]        func_reg, func_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic                     found_reg, found_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]      m_status_reg, m_status_next;
    logic signed [DATA_W-1:0] m_entry_reg, m_entry_next;
    logic [COUNT_W-1:0]       m_count_reg, m_count_next;
    logic                     m_last_reg, m_last_next;

    logic             out_free;
    logic             last_step;
    logic             match;
    logic [CNT_W-1:0] k_inc;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign k_inc     = CNT_W'(k_reg + 1'b1);
    assign last_step = (k_inc == n_reg);
    assign match     = (head_entry == value_reg);
    assign s_tready  = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        value_next    = value_reg;
        fill_next     = fill_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_status_next = m_status_reg;
        m_entry_next  = m_entry_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        ctrl.op       = OP_HOLD;
        ctrl.phase    = k_reg[0];
        ctrl.fill     = fill_reg;
        ctrl.value    = value_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_func;
                    value_next = s_value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                k_next     = '0;
                n_next     = fill_reg;
                found_next = 1'b0;
                state_next = S_DONE;
                case (func_reg)
                    FN_APPEND: begin
                        if (fill_reg == CNT_W'(DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            ctrl.op     = OP_APPEND;
                            fill_next   = CNT_W'(fill_reg + 1'b1);
                            status_next = ST_OK;
                        end
                    end
                    FN_REMOVE, FN_SEARCH: begin
                        status_next = ST_NOTFOUND;
                        if (fill_reg != '0) begin
                            state_next = S_WALK;
                        end
                    end
                    FN_SORT: begin
                        status_next = ST_OK;
                        if (fill_reg > CNT_W'(1)) begin
                            state_next = S_SORT;
                        end
                    end
                    FN_CLEAR: begin
                        fill_next   = '0;
                        status_next = ST_OK;
                    end
                    FN_READOUT: begin
                        status_next = ST_EMPTY;
                        if (fill_reg != '0) begin
                            state_next = S_WALK;
                        end
                    end
                    default: begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_WALK: begin
                if (func_reg == FN_READOUT) begin
                    if (out_free) begin
                        ctrl.op       = OP_ROTATE;
                        m_tvalid_next = 1'b1;
                        m_status_next = ST_OK;
                        m_entry_next  = head_entry;
                        m_count_next  = COUNT_W'(fill_reg);
                        m_last_next   = last_step;
                        k_next        = k_inc;
                        if (last_step) begin
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    if (func_reg == FN_REMOVE && match && !found_reg) begin
                        ctrl.op   = OP_DROP;
                        fill_next = CNT_W'(fill_reg - 1'b1);
                    end else begin
                        ctrl.op = OP_ROTATE;
                    end
                    found_next = found_reg | match;
                    k_next     = k_inc;
                    if (last_step) begin
                        status_next = (found_reg | match) ? ST_OK : ST_NOTFOUND;
                        state_next  = S_DONE;
                    end
                end
            end
            S_SORT: begin
                ctrl.op = OP_SORT;
                k_next  = k_inc;
                if (last_step) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_entry_next  = '0;
                    m_count_next  = COUNT_W'(fill_reg);
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        value_reg    <= value_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_entry_reg  <= m_entry_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_status = m_status_reg;
    assign m_entry  = m_entry_reg;
    assign m_count  = m_count_reg;
    assign m_last   = m_last_reg;

endmodule

### rtl/bounded_list_store_with_sort_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_store_with_sort_unit
// Ordered list of up to DEPTH signed 32-bit values held in a row of cells,
// with append, remove, sort, clear, search and readout requests.
// ----------------------------------------------------------------------------
// One request is taken at a time. Append, clear, unused codes and any request
// on an empty list pass from decode straight to the done state. Search and
// remove walk the list once as a ring through the cells, one entry per cycle;
// readout gives one transfer per cycle, stalling with the result channel.
// Sort runs fill odd-even exchange phases across the cell row, and a single
// entry needs no phase. The steps through the cell row make search, remove,
// readout and sort take longer as fill grows. The next request is taken
// while the last result still waits.
module bounded_list_store_with_sort_unit import blss_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value
    input  logic [2:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // entry, count, zero fill
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast
);

    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] cell_entry [DEPTH];
    logic                     cell_swap  [DEPTH];
    logic signed [DATA_W-1:0] m_entry;
    logic [COUNT_W-1:0]       m_count;

    blss_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_func     (s_tuser),
        .s_value    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_status   (m_tuser),
        .m_entry    (m_entry),
        .m_count    (m_count),
        .m_last     (m_tlast),
        .head_entry (cell_entry[0]),
        .ctrl       (ctrl)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_entry;
        logic signed [DATA_W-1:0] right_entry;
        logic                     left_swap;

        if (i == 0) begin : g_first
            assign left_entry = '0;
            assign left_swap  = 1'b0;
        end else begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_swap  = cell_swap[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        blss_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .index       (CNT_W'(i)),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .head_entry  (cell_entry[0]),
            .left_swap   (left_swap),
            .entry       (cell_entry[i]),
            .swap_out    (cell_swap[i])
        );
    end

    assign m_tdata = {2'b00, m_count, m_entry};

endmodule

### bench/bounded_list_store_with_sort_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_store_with_sort_unit_test
// Drives append, remove, sort, clear, search, readout and unused requests into
// the list store. A local model of the list predicts every result transfer,
// and a monitor compares status, entry, count and last in order. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module bounded_list_store_with_sort_unit_test import blss_pkg::*; ;

    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
    localparam int RANDOM_ITEMS = 300;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 45;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] entry;
        logic [COUNT_W-1:0]       count;
        logic                     last;
    } outcome_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // value
    logic [2:0]  s_tuser  = '0;   // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // entry, count, zero fill
    logic [1:0]  m_tuser;         // status
    logic        m_tlast;

    request_t                 request_queue[$];
    outcome_t                 pending_outcomes[$];
    logic signed [DATA_W-1:0] value_pool[$];
    logic signed [DATA_W-1:0] list_mem[DEPTH];
    int                       list_len = 0;
    int                       cycle_count = 0;
    int                       accepted_requests = 0;
    int                       mismatch_count = 0;
    int                       send_gap = 0;
    int                       ready_gap = 0;
    logic                     long_hold_done = 1'b0;
    request_t                 next_req;

    bounded_list_store_with_sort_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (cycle_count % 512 >= 384) return 0;   // calm stretch
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void queue_outcome(logic [STATUS_W-1:0] status,
                                          logic signed [DATA_W-1:0] entry, logic last);
        outcome_t o;
        o.status = status;
        o.entry  = entry;
        o.count  = list_len[COUNT_W-1:0];
        o.last   = last;
        pending_outcomes.push_back(o);
    endfunction

    function automatic void apply_request(logic [FUNC_W-1:0] func,
                                          logic signed [DATA_W-1:0] value);
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] swap;
        int                       hit;
        status = ST_OK;
        hit = -1;
        case (func)
            FN_APPEND: begin
                if (list_len >= DEPTH) begin
                    status = ST_FULL;
                end else begin
                    list_mem[list_len] = value;
                    list_len++;
                end
            end
            FN_REMOVE, FN_SEARCH: begin
                for (int i = 0; i < list_len && hit < 0; i++)
                    if (list_mem[i] == value) hit = i;
                status = (hit < 0) ? ST_NOTFOUND : ST_OK;
                if (func == FN_REMOVE && hit >= 0) begin
                    for (int j = hit; j + 1 < list_len; j++) list_mem[j] = list_mem[j + 1];
                    list_len--;
                end
            end
            FN_SORT: begin
                for (int i = 0; i < list_len; i++)
                    for (int j = 0; j + 1 < list_len; j++)
                        if (list_mem[j] > list_mem[j + 1]) begin
                            swap            = list_mem[j];
                            list_mem[j]     = list_mem[j + 1];
                            list_mem[j + 1] = swap;
                        end
            end
            FN_CLEAR: begin
                list_len = 0;
            end
            FN_READOUT: begin
                if (list_len == 0) begin
                    queue_outcome(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < list_len; i++)
                        queue_outcome(ST_OK, list_mem[i], i == list_len - 1);
                end
                return;
            end
            default: ;
        endcase
        queue_outcome(status, '0, 1'b1);
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata);
                accepted_requests <= accepted_requests + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    next_req = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.func;
                    s_tdata  <= next_req.value;
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            ready_gap <= 0;
        end else if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
            m_tready  <= 1'b0;
        end else if (!long_hold_done && accepted_requests >= HOLD_AFTER) begin
            long_hold_done <= 1'b1;
            ready_gap      <= LONG_HOLD;
            m_tready       <= 1'b0;
        end else begin
            m_tready  <= 1'b1;
            ready_gap <= pick_gap();
        end
    end

    // result monitor
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected transfer: status %0d entry %0d count %0d last %0d",
                             m_tuser, $signed(m_tdata[31:0]), m_tdata[37:32], m_tlast);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_tuser !== want.status || m_tdata[31:0] !== want.entry
                        || m_tdata[37:32] !== want.count || m_tlast !== want.last) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) begin
                        $write("mismatch: expected status %0d entry %0d count %0d last %0d,",
                               want.status, want.entry, want.count, want.last);
                        $display(" got status %0d entry %0d count %0d last %0d",
                                 m_tuser, $signed(m_tdata[31:0]), m_tdata[37:32], m_tlast);
                    end
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic add_request(logic [FUNC_W-1:0] func, logic signed [DATA_W-1:0] value);
        request_t r;
        r.func  = func;
        r.value = value;
        request_queue.push_back(r);
        if (func == FN_APPEND) begin
            value_pool.push_back(value);
            if (value_pool.size() > 64) void'(value_pool.pop_front());
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $signed($urandom_range(0, 16)) - 8;
        if (r < 55) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_operand();
        if (value_pool.size() > 0 && $urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        return pick_value();
    endfunction

    initial begin
        int n;
        int issued;
        int kind;
        // directed: empty list first, then extremes, duplicates and the tail
        add_request(FN_READOUT, 0);
        add_request(FN_SEARCH, 0);
        add_request(FN_REMOVE, 5);
        add_request(FN_SORT, 0);
        add_request(FN_CLEAR, 0);
        add_request(FN_SPARE_A, 32'sh7fffffff);
        add_request(FN_SPARE_B, 32'sh80000000);
        add_request(FN_APPEND, 32'sh7fffffff);
        add_request(FN_APPEND, 32'sh80000000);
        add_request(FN_APPEND, 0);
        add_request(FN_APPEND, 32'sh80000000);
        add_request(FN_APPEND, -1);
        add_request(FN_SEARCH, -1);
        add_request(FN_SEARCH, 1);
        add_request(FN_REMOVE, 32'sh80000000);
        add_request(FN_REMOVE, 12345);
        add_request(FN_READOUT, 0);
        add_request(FN_SORT, 0);
        add_request(FN_READOUT, 0);
        add_request(FN_SPARE_A, 0);
        add_request(FN_CLEAR, 0);
        add_request(FN_READOUT, 0);

        // random: start by overfilling, then mixed sequences
        issued = 0;
        for (int i = 0; i < DEPTH + 4; i++) add_request(FN_APPEND, pick_value());
        add_request(FN_SEARCH, request_queue[request_queue.size() - 5].value);
        add_request(FN_READOUT, 0);
        add_request(FN_SORT, 0);
        add_request(FN_READOUT, 0);
        issued = DEPTH + 8;
        while (issued < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    n = $urandom_range(3, 40);
                    for (int i = 0; i < n; i++) add_request(FN_APPEND, pick_value());
                    issued += n;
                end
                3, 4, 5: begin
                    n = $urandom_range(4, 12);
                    for (int i = 0; i < n; i++) begin
                        case ($urandom_range(0, 5))
                            0, 1:    add_request(FN_SEARCH, pick_operand());
                            2, 3:    add_request(FN_REMOVE, pick_operand());
                            4:       add_request(FN_APPEND, pick_value());
                            default: add_request(FN_READOUT, $urandom);
                        endcase
                    end
                    issued += n;
                end
                6: begin
                    add_request(FN_SORT, $urandom);
                    add_request(FN_READOUT, 0);
                    issued += 2;
                end
                7: begin
                    add_request(FN_READOUT, $urandom);
                    issued += 1;
                end
                8: begin
                    add_request(FN_CLEAR, $urandom);
                    add_request(FN_READOUT, 0);
                    issued += 2;
                end
                default: begin
                    add_request($urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B, $urandom);
                    add_request(FN_REMOVE, $urandom);
                    add_request(FN_SEARCH, $urandom);
                    issued += 3;
                end
            endcase
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
